### src/shl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shl_pkg;

   // Sizing
   localparam int OFFSET_BITS   = 16;
   localparam int MAX_WORD_LEN  = 6;
   localparam int SPAN_BITS     = 16;
   localparam int CNT_BITS      = $clog2(MAX_WORD_LEN + 1);
   localparam int IDX_BITS      = $clog2(MAX_WORD_LEN);
   localparam int WIDE_BITS     = OFFSET_BITS + SPAN_BITS;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   typedef logic [OFFSET_BITS-1:0] offset_type;
   typedef logic [MAX_WORD_LEN-1:0][7:0] word_buf_type;

   localparam offset_type OFFSET_MAX = {OFFSET_BITS{1'b1}};
   localparam logic [SPAN_BITS-1:0] SPAN_MAX = {SPAN_BITS{1'b1}};

   // Characters
   localparam logic [7:0] CHAR_SLASH      = 8'h2F;
   localparam logic [7:0] CHAR_DOT        = 8'h2E;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_SLASH   = 3'd1,
      MODE_DOT     = 3'd2,
      MODE_NUMBER  = 3'd3,
      MODE_IDENT   = 3'd4,
      MODE_COMMENT = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      CLASS_COMMENT = 3'd0,
      CLASS_NUMBER  = 3'd1,
      CLASS_KEYWORD = 3'd2,
      CLASS_BUILTIN = 3'd3,
      CLASS_BOOL    = 3'd4
   } color_type;

   // One queued span: offsets as seen by the lexer, clipped later
   typedef struct packed {
      offset_type start;
      offset_type stop;
      color_type  cls;
      logic       last;
   } span_type;

   // Up to two spans per request, packed toward slot 0
   typedef struct packed {
      logic [1:0] count;
      span_type   span0;
      span_type   span1;
   } push_type;

   typedef struct packed {
      logic      hit;
      color_type cls;
   } match_type;

   // Word list, text left-aligned and space padded
   localparam int WORD_TEXT_LEN   = 6;
   localparam int WORD_TABLE_SIZE = 19;

   localparam logic [8*WORD_TEXT_LEN-1:0] WORD_TEXT [WORD_TABLE_SIZE] = '{
      "let   ", "if    ", "else  ", "while ", "repeat", "and   ", "or    ",
      "player", "camera", "obj   ", "color ", "wait  ", "abs   ", "min   ",
      "max   ", "sin   ", "cos   ", "true  ", "false "
   };

   localparam logic [CNT_BITS-1:0] WORD_LEN [WORD_TABLE_SIZE] = '{
      CNT_BITS'(3), CNT_BITS'(2), CNT_BITS'(4), CNT_BITS'(5), CNT_BITS'(6),
      CNT_BITS'(3), CNT_BITS'(2), CNT_BITS'(6), CNT_BITS'(6), CNT_BITS'(3),
      CNT_BITS'(5), CNT_BITS'(4), CNT_BITS'(3), CNT_BITS'(3), CNT_BITS'(3),
      CNT_BITS'(3), CNT_BITS'(3), CNT_BITS'(4), CNT_BITS'(5)
   };

   localparam color_type WORD_CLASS [WORD_TABLE_SIZE] = '{
      CLASS_KEYWORD, CLASS_KEYWORD, CLASS_KEYWORD, CLASS_KEYWORD, CLASS_KEYWORD,
      CLASS_KEYWORD, CLASS_KEYWORD, CLASS_BUILTIN, CLASS_BUILTIN, CLASS_BUILTIN,
      CLASS_BUILTIN, CLASS_BUILTIN, CLASS_BUILTIN, CLASS_BUILTIN, CLASS_BUILTIN,
      CLASS_BUILTIN, CLASS_BUILTIN, CLASS_BOOL, CLASS_BOOL
   };

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CHAR_UNDERSCORE);
   endfunction

   // Parallel compare of the word against every list entry
   function automatic match_type word_lookup(input word_buf_type wb,
                                             input logic [CNT_BITS-1:0] cnt);
      match_type m;
      logic      eq;
      m.hit = 1'b0;
      m.cls = CLASS_KEYWORD;
      for (int e = 0; e < WORD_TABLE_SIZE; e++) begin
         eq = (WORD_LEN[e] == cnt);
         for (int i = 0; i < WORD_TEXT_LEN; i++) begin
            if ((i < int'(cnt)) &&
                (wb[i] != WORD_TEXT[e][8*(WORD_TEXT_LEN-1-i) +: 8])) begin
               eq = 1'b0;
            end
         end
         if (eq && !m.hit) begin
            m.hit = 1'b1;
            m.cls = WORD_CLASS[e];
         end
      end
      return m;
   endfunction

   // Clip an offset to the span field width
   function automatic logic [SPAN_BITS-1:0] clip_span(input offset_type v);
      logic [WIDE_BITS-1:0] wide;
      wide = {{SPAN_BITS{1'b0}}, v};
      if (wide > WIDE_BITS'(SPAN_MAX)) begin
         return SPAN_MAX;
      end
      return wide[SPAN_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

### src/shl_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface shl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface shl_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] span_start;
   logic [15:0] span_length;
   logic [2:0]  color_class;
   logic        last_in_run;

   modport source (output valid, output span_start, output span_length,
                   output color_class, output last_in_run, input ready);
   modport sink   (input valid, input span_start, input span_length,
                   input color_class, input last_in_run, output ready);
endinterface

`default_nettype wire

### src/syntax_highlight_lexer.sv
// A span closed by a request byte is written into the span queue, then moved into the output register that drives rsp.
// Throughput: one text byte per cycle while the span queue has room; a byte closes at most two spans,
// so req only drops once rsp stalls long enough to leave three spans queued.
// The front lexes a byte in the cycle it is accepted (mode step plus parallel word compare).
// Reset (synchronous, active high): mode idle, offset zero, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none

module syntax_highlight_lexer (
   input  wire logic    clock,
   input  wire logic    reset,
   shl_req_if.sink      req_bus,
   shl_rsp_if.source    rsp_bus
);
   import shl_pkg::*;

   logic      accept;
   logic      has_room;
   logic      not_empty;
   logic      pop;
   push_type  push;
   span_type  head;

   // A request is taken whenever two queue slots are free, so the front
   // can always park both spans a byte may close.
   assign req_bus.ready = has_room;
   assign accept        = req_bus.valid && has_room;

   // Front: lexer state machine, word buffer and keyword match
   shl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_bus.text_byte),
      .end_of_text (req_bus.end_of_text),
      .push        (push)
   );

   // Span queue between front and back
   shl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .has_room  (has_room)
   );

   // Back: length, clipping and the output register
   shl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .not_empty  (not_empty),
      .pop        (pop),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_start  (rsp_bus.span_start),
      .rsp_length (rsp_bus.span_length),
      .rsp_class  (rsp_bus.color_class),
      .rsp_last   (rsp_bus.last_in_run)
   );

endmodule

`default_nettype wire

### src/shl_front.sv
`timescale 1ns / 1ps
`default_nettype none

module shl_front (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic [7:0]     text_byte,
   input  wire logic           end_of_text,
   output shl_pkg::push_type   push
);
   import shl_pkg::*;

   mode_type                mode_ff, mode_in, mode_mid, idle_mode;
   offset_type              offset_ff, offset_in, next_off;
   offset_type              tstart_ff, tstart_in;
   word_buf_type            buf_ff, buf_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    ovf_ff, ovf_in;
   logic                    restart;
   logic                    span_a, span_b;
   span_type                a_span, b_span;
   match_type               match;

   assign next_off = (offset_ff != OFFSET_MAX) ? offset_ff + 1'b1 : offset_ff;

   // Mode a byte takes when lexed from idle
   always_comb begin
      idle_mode = MODE_IDLE;
      if (text_byte == CHAR_SLASH && !end_of_text) begin
         idle_mode = MODE_SLASH;
      end else if (text_byte == CHAR_DOT && !end_of_text) begin
         idle_mode = MODE_DOT;
      end else if (is_digit(text_byte)) begin
         idle_mode = MODE_NUMBER;
      end else if (is_alpha(text_byte) || text_byte == CHAR_UNDERSCORE) begin
         idle_mode = MODE_IDENT;
      end
   end

   // Next state
   always_comb begin
      mode_mid = mode_ff;
      restart  = 1'b0;
      unique case (mode_ff)
         MODE_SLASH: begin
            if (text_byte == CHAR_SLASH) mode_mid = MODE_COMMENT;
            else restart = 1'b1;
         end
         MODE_DOT: begin
            if (is_digit(text_byte)) mode_mid = MODE_NUMBER;
            else restart = 1'b1;
         end
         MODE_NUMBER: begin
            if (!(is_digit(text_byte) || text_byte == CHAR_DOT)) restart = 1'b1;
         end
         MODE_IDENT: begin
            if (!is_word(text_byte)) restart = 1'b1;
         end
         MODE_COMMENT: begin
            if (text_byte == CHAR_NEWLINE) mode_mid = MODE_IDLE;
         end
         MODE_IDLE: restart = 1'b1;
         default:   restart = 1'b1;
      endcase
      if (restart) mode_mid = idle_mode;

      mode_in   = end_of_text ? MODE_IDLE : mode_mid;
      offset_in = end_of_text ? '0 : next_off;
      tstart_in = (restart && idle_mode != MODE_IDLE) ? offset_ff : tstart_ff;

      buf_in = buf_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (mode_ff == MODE_IDENT && is_word(text_byte)) begin
         if (cnt_ff < CNT_BITS'(MAX_WORD_LEN)) begin
            buf_in[cnt_ff[IDX_BITS-1:0]] = text_byte;
            cnt_in = cnt_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end else if (restart && idle_mode == MODE_IDENT) begin
         buf_in[0] = text_byte;
         cnt_in    = CNT_BITS'(1);
         ovf_in    = 1'b0;
      end
   end

   // At most one word closes per byte; its text is the updated buffer
   assign match = word_lookup(buf_in, cnt_in);

   // Outputs: span closed by this byte (a) and end-of-text flush (b)
   always_comb begin
      span_a       = 1'b0;
      a_span.start = tstart_ff;
      a_span.stop  = offset_ff;
      a_span.cls   = CLASS_NUMBER;
      a_span.last  = 1'b1;
      unique case (mode_ff)
         MODE_NUMBER:  span_a = restart;
         MODE_IDENT: begin
            span_a     = restart && !ovf_in && match.hit;
            a_span.cls = match.cls;
         end
         MODE_COMMENT: begin
            span_a     = (text_byte == CHAR_NEWLINE);
            a_span.cls = CLASS_COMMENT;
         end
         default: span_a = 1'b0;
      endcase

      span_b       = 1'b0;
      b_span.start = tstart_in;
      b_span.stop  = next_off;
      b_span.cls   = CLASS_NUMBER;
      b_span.last  = 1'b1;
      if (end_of_text) begin
         unique case (mode_mid)
            MODE_NUMBER:  span_b = 1'b1;
            MODE_IDENT: begin
               span_b     = !ovf_in && match.hit;
               b_span.cls = match.cls;
            end
            MODE_COMMENT: begin
               span_b     = 1'b1;
               b_span.cls = CLASS_COMMENT;
            end
            default: span_b = 1'b0;
         endcase
      end

      push.count = accept ? (2'(span_a) + 2'(span_b)) : 2'd0;
      push.span0 = span_a ? a_span : b_span;
      push.span0.last = !(span_a && span_b);
      push.span1 = b_span;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         offset_ff <= '0;
         tstart_ff <= '0;
         cnt_ff    <= '0;
         ovf_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         offset_ff <= offset_in;
         tstart_ff <= tstart_in;
         cnt_ff    <= cnt_in;
         ovf_ff    <= ovf_in;
      end
   end

   // Word buffer: only the slots below the word count hold bytes of the current word
   always_ff @(posedge clock) begin
      if (accept) buf_ff <= buf_in;
   end

endmodule

`default_nettype wire

### src/shl_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module shl_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire shl_pkg::push_type push,
   input  wire logic          pop,
   output shl_pkg::span_type  head,
   output logic               not_empty,
   output logic               has_room
);
   import shl_pkg::*;

   span_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]    wr_ff, rd_ff;
   logic [QCNT_BITS-1:0]    count_ff, count_in;
   logic                    do_pop;

   assign not_empty = (count_ff != '0);
   assign has_room  = (count_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));
   assign head      = entry_ff[rd_ff];
   assign do_pop    = pop && not_empty;
   assign count_in  = count_ff + QCNT_BITS'(push.count) - QCNT_BITS'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_ff + QPTR_BITS'(push.count);
         rd_ff    <= rd_ff + QPTR_BITS'(do_pop);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ff] <= push.span0;
      if (push.count == 2'd2) entry_ff[wr_ff + 1'b1] <= push.span1;
   end

endmodule

`default_nettype wire

### src/shl_back.sv
`timescale 1ns / 1ps
`default_nettype none

module shl_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire shl_pkg::span_type head,
   input  wire logic          not_empty,
   output logic               pop,
   input  wire logic          rsp_ready,
   output logic               rsp_valid,
   output logic [15:0]        rsp_start,
   output logic [15:0]        rsp_length,
   output logic [2:0]         rsp_class,
   output logic               rsp_last
);
   import shl_pkg::*;

   logic                  valid_ff;
   logic [SPAN_BITS-1:0]  start_ff, length_ff;
   logic [2:0]            class_ff;
   logic                  last_ff;
   offset_type            length_in;

   assign pop       = not_empty && (!valid_ff || rsp_ready);
   assign length_in = head.stop - head.start;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         start_ff  <= clip_span(head.start);
         length_ff <= clip_span(length_in);
         class_ff  <= head.cls;
         last_ff   <= head.last;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_start  = start_ff;
   assign rsp_length = length_ff;
   assign rsp_class  = class_ff;
   assign rsp_last   = last_ff;

endmodule

`default_nettype wire

### src/shl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module shl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_start,
   input wire logic [15:0] rsp_length,
   input wire logic [2:0]  rsp_class,
   input wire logic        rsp_last
);
   import shl_pkg::*;

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Class stays within the defined codes
   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_class <= 3'(CLASS_BOOL)))
      else $error("bad color class");

   // Stalled span is held
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("span dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_start) && $stable(rsp_length) &&
                                  $stable(rsp_class) && $stable(rsp_last))
      else $error("span changed while stalled");

endmodule

bind syntax_highlight_lexer shl_checker u_shl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_start  (rsp_bus.span_start),
   .rsp_length (rsp_bus.span_length),
   .rsp_class  (rsp_bus.color_class),
   .rsp_last   (rsp_bus.last_in_run)
);

`default_nettype wire
